### rtl/kdlp_pkg.sv
package kdlp_pkg;

   // key phase codes
   localparam logic [1:0] PHASE_IDLE    = 2'd0;
   localparam logic [1:0] PHASE_PRESSED = 2'd1;
   localparam logic [1:0] PHASE_LONG    = 2'd2;

   // event codes
   localparam logic [2:0] EV_NONE         = 3'd0;
   localparam logic [2:0] EV_PRESS        = 3'd1;
   localparam logic [2:0] EV_CLICK        = 3'd2;
   localparam logic [2:0] EV_LONG_PRESS   = 3'd3;
   localparam logic [2:0] EV_LONG_RELEASE = 3'd4;

   // item actions
   localparam logic ACT_SCAN = 1'b0;
   localparam logic ACT_READ = 1'b1;

   // register indexes
   localparam logic [1:0] CSR_KEY_ENABLE  = 2'd0;
   localparam logic [1:0] CSR_ACTIVE_HIGH = 2'd1;
   localparam logic [1:0] CSR_DEBOUNCE    = 2'd2;
   localparam logic [1:0] CSR_LONG_PRESS  = 2'd3;

   localparam logic [15:0] DEBOUNCE_RESET   = 16'd20;
   localparam logic [15:0] LONG_PRESS_RESET = 16'd1000;

   // the raw level, enable and polarity words are eight bits wide
   localparam int MAX_LANES = 8;

   typedef struct packed {
      logic [1:0] phase;
      logic [2:0] evt;
   } lane_status_type;

   typedef struct packed {
      logic [1:0] key_state;
      logic [2:0] key_event;
      logic [7:0] pending_mask;
   } result_type;

endpackage

### rtl/kdlp_if.sv
interface kdlp_req_if;
   logic        valid;
   logic        ready;
   logic        action;
   logic [31:0] now_ms;
   logic [7:0]  raw_levels;
   logic [2:0]  key_index;

   modport source (output valid, output action, output now_ms, output raw_levels,
                   output key_index, input ready);
   modport sink (input valid, input action, input now_ms, input raw_levels,
                 input key_index, output ready);
endinterface

interface kdlp_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] key_state_out;
   logic [2:0] key_event_out;
   logic [7:0] pending_mask;

   modport source (output valid, output key_state_out, output key_event_out,
                   output pending_mask, input ready);
   modport sink (input valid, input key_state_out, input key_event_out,
                 input pending_mask, output ready);
endinterface

### rtl/kdlp_lane.sv
module kdlp_lane (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     scan_en,
   input  logic                     clear_en,
   input  logic [31:0]              now_ms,
   input  logic                     raw_bit,
   input  logic                     polarity_bit,
   input  logic [15:0]              debounce_ms,
   input  logic [15:0]              long_press_ms,
   output kdlp_pkg::lane_status_type cur_status,
   output kdlp_pkg::lane_status_type next_status
);

   logic        last_level_ff, last_level_in;
   logic [31:0] change_stamp_ff, change_stamp_in;
   logic [1:0]  phase_ff, phase_in;
   logic [2:0]  pending_ff, pending_in;

   logic        level;
   logic        changed;
   logic [31:0] elapsed;
   logic        stable;
   logic        held_long;

   // pressed when the pin matches its polarity bit
   assign level     = raw_bit ~^ polarity_bit;
   assign changed   = level != last_level_ff;
   assign elapsed   = changed ? 32'd0 : (now_ms - change_stamp_ff);
   assign stable    = elapsed > {16'd0, debounce_ms};
   assign held_long = elapsed > {16'd0, long_press_ms};

   always_comb begin
      last_level_in   = last_level_ff;
      change_stamp_in = change_stamp_ff;
      phase_in        = phase_ff;
      pending_in      = pending_ff;
      if (scan_en) begin
         if (changed) begin
            last_level_in   = level;
            change_stamp_in = now_ms;
         end
         if (stable) begin
            if (level && phase_ff == kdlp_pkg::PHASE_IDLE) begin
               phase_in   = kdlp_pkg::PHASE_PRESSED;
               pending_in = kdlp_pkg::EV_PRESS;
            end else if (!level && phase_ff != kdlp_pkg::PHASE_IDLE) begin
               pending_in = (phase_ff == kdlp_pkg::PHASE_LONG) ?
                            kdlp_pkg::EV_LONG_RELEASE : kdlp_pkg::EV_CLICK;
               phase_in   = kdlp_pkg::PHASE_IDLE;
            end
            // press and long press in one scan collapse to long press
            if (level && phase_in == kdlp_pkg::PHASE_PRESSED && held_long) begin
               phase_in   = kdlp_pkg::PHASE_LONG;
               pending_in = kdlp_pkg::EV_LONG_PRESS;
            end
         end
      end
      if (clear_en) begin
         pending_in = kdlp_pkg::EV_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_level_ff   <= 1'b0;
         change_stamp_ff <= 32'd0;
         phase_ff        <= kdlp_pkg::PHASE_IDLE;
         pending_ff      <= kdlp_pkg::EV_NONE;
      end else begin
         last_level_ff   <= last_level_in;
         change_stamp_ff <= change_stamp_in;
         phase_ff        <= phase_in;
         pending_ff      <= pending_in;
      end
   end

   assign cur_status.phase  = phase_ff;
   assign cur_status.evt    = pending_ff;
   assign next_status.phase = phase_in;
   assign next_status.evt   = pending_in;

endmodule

### rtl/kdlp_merge.sv
module kdlp_merge #(
   parameter int LANES = 8
) (
   input  logic                      action,
   input  logic [2:0]                key_index,
   input  logic [LANES-1:0]          enable,
   input  kdlp_pkg::lane_status_type cur_status  [LANES],
   input  kdlp_pkg::lane_status_type next_status [LANES],
   output kdlp_pkg::result_type      result
);

   always_comb begin
      result.key_state    = kdlp_pkg::PHASE_IDLE;
      result.key_event    = kdlp_pkg::EV_NONE;
      result.pending_mask = 8'd0;
      for (int k = 0; k < LANES; k++) begin
         if (enable[k] && key_index == 3'(k)) begin
            result.key_state = next_status[k].phase;
            if (action == kdlp_pkg::ACT_READ) begin
               result.key_event = cur_status[k].evt;
            end
         end
         result.pending_mask[k] = enable[k] && (next_status[k].evt != kdlp_pkg::EV_NONE);
      end
   end

endmodule

### rtl/key_debounce_long_press_unit.sv
// Debouncer with press, click, long-press and long-release detection for up to
// eight keys. Each key has its own lane (level normalize, timer subtract, two
// compares, phase update), so a scan or read word is taken every cycle and its
// result word is loaded into the output register when it is accepted. The
// input stalls only while that register is full and the result is not being
// taken. Timestamps wrap modulo 2^32; a scan result carries event 0, a read
// returns and clears the indexed key's pending event. Write the control
// registers only while no word is in flight. Keys at or beyond eight are never
// enabled and get no lane.
module key_debounce_long_press_unit #(
   parameter int NUM_KEYS = 8
) (
   input  logic        clock,
   input  logic        reset,
   kdlp_req_if.sink    req_ch,
   kdlp_rsp_if.source  rsp_ch,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   localparam int LANES = (NUM_KEYS < kdlp_pkg::MAX_LANES) ? NUM_KEYS : kdlp_pkg::MAX_LANES;

   logic [7:0]  key_enable_ff;
   logic [7:0]  active_high_ff;
   logic [15:0] debounce_ff;
   logic [15:0] long_press_ff;

   logic rsp_valid_ff, rsp_valid_in;
   kdlp_pkg::result_type rsp_data_ff;
   kdlp_pkg::result_type merged;

   logic accept;
   logic [LANES-1:0] scan_en;
   logic [LANES-1:0] clear_en;
   kdlp_pkg::lane_status_type cur_status  [LANES];
   kdlp_pkg::lane_status_type next_status [LANES];

   always_ff @(posedge clock) begin
      if (reset) begin
         key_enable_ff  <= 8'd0;
         active_high_ff <= 8'd0;
         debounce_ff    <= kdlp_pkg::DEBOUNCE_RESET;
         long_press_ff  <= kdlp_pkg::LONG_PRESS_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            kdlp_pkg::CSR_KEY_ENABLE:  key_enable_ff  <= csr_wdata[7:0];
            kdlp_pkg::CSR_ACTIVE_HIGH: active_high_ff <= csr_wdata[7:0];
            kdlp_pkg::CSR_DEBOUNCE:    debounce_ff    <= csr_wdata;
            kdlp_pkg::CSR_LONG_PRESS:  long_press_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign accept       = req_ch.valid && req_ch.ready;

   for (genvar k = 0; k < LANES; k++) begin : g_lane
      assign scan_en[k]  = accept && req_ch.action == kdlp_pkg::ACT_SCAN && key_enable_ff[k];
      assign clear_en[k] = accept && req_ch.action == kdlp_pkg::ACT_READ && key_enable_ff[k]
                           && req_ch.key_index == 3'(k);

      kdlp_lane u_lane (
         .clock         (clock),
         .reset         (reset),
         .scan_en       (scan_en[k]),
         .clear_en      (clear_en[k]),
         .now_ms        (req_ch.now_ms),
         .raw_bit       (req_ch.raw_levels[k]),
         .polarity_bit  (active_high_ff[k]),
         .debounce_ms   (debounce_ff),
         .long_press_ms (long_press_ff),
         .cur_status    (cur_status[k]),
         .next_status   (next_status[k])
      );
   end

   kdlp_merge #(
      .LANES (LANES)
   ) u_merge (
      .action      (req_ch.action),
      .key_index   (req_ch.key_index),
      .enable      (key_enable_ff[LANES-1:0]),
      .cur_status  (cur_status),
      .next_status (next_status),
      .result      (merged)
   );

   // result register: loads on accept, drains when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= merged;
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.key_state_out = rsp_data_ff.key_state;
   assign rsp_ch.key_event_out = rsp_data_ff.key_event;
   assign rsp_ch.pending_mask  = rsp_data_ff.pending_mask;

`ifndef SYNTHESIS
   // a read of enabled key 0 clears the pending event of that key
   a_read_clears: assert property (@(posedge clock) disable iff (reset)
      (accept && req_ch.action == kdlp_pkg::ACT_READ && req_ch.key_index == 3'd0
       && key_enable_ff[0])
      |=> cur_status[0].evt == kdlp_pkg::EV_NONE)
      else $error("read did not clear key 0 event");

   // a pending press is only ever seen with the key still pressed
   a_press_phase: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.key_event == kdlp_pkg::EV_PRESS)
      |-> rsp_data_ff.key_state == kdlp_pkg::PHASE_PRESSED)
      else $error("press event without pressed phase");

   a_long_phase: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.key_event == kdlp_pkg::EV_LONG_PRESS)
      |-> rsp_data_ff.key_state == kdlp_pkg::PHASE_LONG)
      else $error("long press event without long phase");

   a_release_phase: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_data_ff.key_event == kdlp_pkg::EV_CLICK
                        || rsp_data_ff.key_event == kdlp_pkg::EV_LONG_RELEASE))
      |-> rsp_data_ff.key_state == kdlp_pkg::PHASE_IDLE)
      else $error("release event without idle phase");

   // a scan never reports an event
   a_scan_no_event: assert property (@(posedge clock) disable iff (reset)
      (accept && req_ch.action == kdlp_pkg::ACT_SCAN)
      |=> rsp_data_ff.key_event == kdlp_pkg::EV_NONE)
      else $error("scan result carries an event");
`endif

endmodule

### dv/tb_key_debounce_long_press_unit.sv
`timescale 1ns / 100ps

module tb_key_debounce_long_press_unit;

   typedef enum logic {ROW_WORD, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type          kind;
      logic [1:0]            reg_sel;
      logic [15:0]           reg_val;
      logic                  action;
      logic [31:0]           now_ms;
      logic [7:0]            raw_levels;
      logic [2:0]            key_index;
      logic                  fixed;      // report typed in below, not predicted
      kdlp_pkg::result_type  fixed_rpt;
   } stim_row_type;

   localparam kdlp_pkg::result_type IDLE_REPORT =
      '{kdlp_pkg::PHASE_IDLE, kdlp_pkg::EV_NONE, 8'h00};

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic        csr_we;
   logic [1:0]  csr_index;
   logic [15:0] csr_wdata;

   kdlp_req_if req_ch();
   kdlp_rsp_if rsp_ch();

   key_debounce_long_press_unit DUT (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   // key state mirror
   logic [7:0]  cfg_enable;
   logic [7:0]  cfg_polarity;
   logic [15:0] cfg_debounce;
   logic [15:0] cfg_long;
   logic        seen_level   [kdlp_pkg::MAX_LANES];
   logic [31:0] settle_stamp [kdlp_pkg::MAX_LANES];
   logic [1:0]  hold_phase   [kdlp_pkg::MAX_LANES];
   logic [2:0]  unread_evt   [kdlp_pkg::MAX_LANES];

   kdlp_pkg::result_type awaited_reports [$];
   int                   mismatch_count = 0;
   int                   burst_left = 0;
   logic                 long_hold_req = 1'b0;
   logic                 pin_valid;
   kdlp_pkg::result_type pin_rpt;

   stim_row_type directed_rows [$] = '{
      // nothing enabled yet
      '{ROW_WORD, kdlp_pkg::CSR_KEY_ENABLE, 16'h0000, kdlp_pkg::ACT_READ, 32'h0000_0000,
        8'h00, 3'd0, 1'b1, IDLE_REPORT},
      '{ROW_WORD, kdlp_pkg::CSR_KEY_ENABLE, 16'h0000, kdlp_pkg::ACT_SCAN, 32'hFFFF_FFFF,
        8'hFF, 3'd7, 1'b1, IDLE_REPORT},
      '{ROW_CSR, kdlp_pkg::CSR_KEY_ENABLE, 16'h00FF, kdlp_pkg::ACT_SCAN, 32'd0,
        8'h00, 3'd0, 1'b0, IDLE_REPORT},
      '{ROW_CSR, kdlp_pkg::CSR_ACTIVE_HIGH, 16'h00F0, kdlp_pkg::ACT_SCAN, 32'd0,
        8'h00, 3'd0, 1'b0, IDLE_REPORT},
      '{ROW_CSR, kdlp_pkg::CSR_DEBOUNCE, 16'd20, kdlp_pkg::ACT_SCAN, 32'd0,
        8'h00, 3'd0, 1'b0, IDLE_REPORT},
      '{ROW_CSR, kdlp_pkg::CSR_LONG_PRESS, 16'd1000, kdlp_pkg::ACT_SCAN, 32'd0,
        8'h00, 3'd0, 1'b0, IDLE_REPORT},
      // low keys go down, debounce edge at exactly 20 then 21
      '{ROW_WORD, kdlp_pkg::CSR_KEY_ENABLE, 16'h0000, kdlp_pkg::ACT_SCAN, 32'd100,
        8'h00, 3'd0, 1'b0, IDLE_REPORT},
      '{ROW_WORD, kdlp_pkg::CSR_KEY_ENABLE, 16'h0000, kdlp_pkg::ACT_SCAN, 32'd120,
        8'h00, 3'd1, 1'b0, IDLE_REPORT},
      '{ROW_WORD, kdlp_pkg::CSR_KEY_ENABLE, 16'h0000, kdlp_pkg::ACT_SCAN, 32'd121,
        8'h00, 3'd2, 1'b0, IDLE_REPORT},
      '{ROW_WORD, kdlp_pkg::CSR_KEY_ENABLE, 16'h0000, kdlp_pkg::ACT_READ, 32'd0,
        8'h00, 3'd0, 1'b0, IDLE_REPORT},
      '{ROW_WORD, kdlp_pkg::CSR_KEY_ENABLE, 16'h0000, kdlp_pkg::ACT_SCAN, 32'd1121,
        8'h00, 3'd3, 1'b0, IDLE_REPORT},
      '{ROW_WORD, kdlp_pkg::CSR_KEY_ENABLE, 16'h0000, kdlp_pkg::ACT_READ, 32'd0,
        8'h00, 3'd1, 1'b0, IDLE_REPORT},
      // release; key 2 long press overwritten by long release before it is read
      '{ROW_WORD, kdlp_pkg::CSR_KEY_ENABLE, 16'h0000, kdlp_pkg::ACT_SCAN, 32'd1200,
        8'h0F, 3'd4, 1'b0, IDLE_REPORT},
      '{ROW_WORD, kdlp_pkg::CSR_KEY_ENABLE, 16'h0000, kdlp_pkg::ACT_SCAN, 32'd1221,
        8'h0F, 3'd5, 1'b0, IDLE_REPORT},
      '{ROW_WORD, kdlp_pkg::CSR_KEY_ENABLE, 16'h0000, kdlp_pkg::ACT_READ, 32'd0,
        8'h00, 3'd2, 1'b0, IDLE_REPORT},
      '{ROW_WORD, kdlp_pkg::CSR_KEY_ENABLE, 16'h0000, kdlp_pkg::ACT_READ, 32'd0,
        8'h00, 3'd2, 1'b0, IDLE_REPORT},
      // press and long press in the same scan
      '{ROW_CSR, kdlp_pkg::CSR_DEBOUNCE, 16'd5, kdlp_pkg::ACT_SCAN, 32'd0,
        8'h00, 3'd0, 1'b0, IDLE_REPORT},
      '{ROW_CSR, kdlp_pkg::CSR_LONG_PRESS, 16'd3, kdlp_pkg::ACT_SCAN, 32'd0,
        8'h00, 3'd0, 1'b0, IDLE_REPORT},
      '{ROW_WORD, kdlp_pkg::CSR_KEY_ENABLE, 16'h0000, kdlp_pkg::ACT_SCAN, 32'd2000,
        8'hF0, 3'd5, 1'b0, IDLE_REPORT},
      '{ROW_WORD, kdlp_pkg::CSR_KEY_ENABLE, 16'h0000, kdlp_pkg::ACT_SCAN, 32'd2010,
        8'hF0, 3'd6, 1'b0, IDLE_REPORT},
      '{ROW_WORD, kdlp_pkg::CSR_KEY_ENABLE, 16'h0000, kdlp_pkg::ACT_READ, 32'd0,
        8'h00, 3'd5, 1'b0, IDLE_REPORT},
      // timestamp wraps across zero, max settings
      '{ROW_CSR, kdlp_pkg::CSR_DEBOUNCE, 16'hFFFF, kdlp_pkg::ACT_SCAN, 32'd0,
        8'h00, 3'd0, 1'b0, IDLE_REPORT},
      '{ROW_CSR, kdlp_pkg::CSR_LONG_PRESS, 16'hFFFF, kdlp_pkg::ACT_SCAN, 32'd0,
        8'h00, 3'd0, 1'b0, IDLE_REPORT},
      '{ROW_WORD, kdlp_pkg::CSR_KEY_ENABLE, 16'h0000, kdlp_pkg::ACT_SCAN, 32'hFFFF_FFF0,
        8'h00, 3'd4, 1'b0, IDLE_REPORT},
      '{ROW_WORD, kdlp_pkg::CSR_KEY_ENABLE, 16'h0000, kdlp_pkg::ACT_SCAN, 32'h0000_FFEF,
        8'h00, 3'd7, 1'b0, IDLE_REPORT},
      '{ROW_WORD, kdlp_pkg::CSR_KEY_ENABLE, 16'h0000, kdlp_pkg::ACT_SCAN, 32'h0000_FFFF,
        8'h00, 3'd7, 1'b0, IDLE_REPORT},
      '{ROW_WORD, kdlp_pkg::CSR_KEY_ENABLE, 16'h0000, kdlp_pkg::ACT_READ, 32'd0,
        8'h00, 3'd7, 1'b0, IDLE_REPORT},
      // disabled key keeps its event; enabling again does not clear it
      '{ROW_CSR, kdlp_pkg::CSR_KEY_ENABLE, 16'h000F, kdlp_pkg::ACT_SCAN, 32'd0,
        8'h00, 3'd0, 1'b0, IDLE_REPORT},
      '{ROW_WORD, kdlp_pkg::CSR_KEY_ENABLE, 16'h0000, kdlp_pkg::ACT_READ, 32'd0,
        8'h00, 3'd6, 1'b0, IDLE_REPORT},
      '{ROW_WORD, kdlp_pkg::CSR_KEY_ENABLE, 16'h0000, kdlp_pkg::ACT_SCAN, 32'h0001_0100,
        8'hFF, 3'd6, 1'b0, IDLE_REPORT},
      '{ROW_CSR, kdlp_pkg::CSR_KEY_ENABLE, 16'h00FF, kdlp_pkg::ACT_SCAN, 32'd0,
        8'h00, 3'd0, 1'b0, IDLE_REPORT},
      '{ROW_WORD, kdlp_pkg::CSR_KEY_ENABLE, 16'h0000, kdlp_pkg::ACT_READ, 32'd0,
        8'h00, 3'd6, 1'b0, IDLE_REPORT},
      // zero debounce and zero long press
      '{ROW_CSR, kdlp_pkg::CSR_DEBOUNCE, 16'd0, kdlp_pkg::ACT_SCAN, 32'd0,
        8'h00, 3'd0, 1'b0, IDLE_REPORT},
      '{ROW_CSR, kdlp_pkg::CSR_LONG_PRESS, 16'd0, kdlp_pkg::ACT_SCAN, 32'd0,
        8'h00, 3'd0, 1'b0, IDLE_REPORT},
      '{ROW_CSR, kdlp_pkg::CSR_ACTIVE_HIGH, 16'h00FF, kdlp_pkg::ACT_SCAN, 32'd0,
        8'h00, 3'd0, 1'b0, IDLE_REPORT},
      '{ROW_WORD, kdlp_pkg::CSR_KEY_ENABLE, 16'h0000, kdlp_pkg::ACT_SCAN, 32'h0001_0101,
        8'h55, 3'd4, 1'b0, IDLE_REPORT},
      '{ROW_WORD, kdlp_pkg::CSR_KEY_ENABLE, 16'h0000, kdlp_pkg::ACT_SCAN, 32'h0001_0102,
        8'h55, 3'd2, 1'b0, IDLE_REPORT},
      '{ROW_WORD, kdlp_pkg::CSR_KEY_ENABLE, 16'h0000, kdlp_pkg::ACT_READ, 32'd0,
        8'h00, 3'd4, 1'b0, IDLE_REPORT}
   };

   function automatic kdlp_pkg::result_type next_key_report(input logic act,
                                                            input logic [31:0] now,
                                                            input logic [7:0] raw,
                                                            input logic [2:0] idx);
      kdlp_pkg::result_type rpt;
      logic                 lvl;
      logic [31:0]          held;
      rpt = IDLE_REPORT;
      if (act == kdlp_pkg::ACT_SCAN) begin
         for (int k = 0; k < kdlp_pkg::MAX_LANES; k++) begin
            if (cfg_enable[k]) begin
               lvl = (raw[k] == cfg_polarity[k]);
               if (lvl != seen_level[k]) begin
                  settle_stamp[k] = now;
                  seen_level[k] = lvl;
               end
               held = now - settle_stamp[k];
               if (held > {16'd0, cfg_debounce}) begin
                  if (lvl && hold_phase[k] == kdlp_pkg::PHASE_IDLE) begin
                     hold_phase[k] = kdlp_pkg::PHASE_PRESSED;
                     unread_evt[k] = kdlp_pkg::EV_PRESS;
                  end else if (!lvl && hold_phase[k] != kdlp_pkg::PHASE_IDLE) begin
                     unread_evt[k] = (hold_phase[k] == kdlp_pkg::PHASE_LONG) ?
                                     kdlp_pkg::EV_LONG_RELEASE : kdlp_pkg::EV_CLICK;
                     hold_phase[k] = kdlp_pkg::PHASE_IDLE;
                  end
                  if (lvl && hold_phase[k] == kdlp_pkg::PHASE_PRESSED
                      && held > {16'd0, cfg_long}) begin
                     hold_phase[k] = kdlp_pkg::PHASE_LONG;
                     unread_evt[k] = kdlp_pkg::EV_LONG_PRESS;
                  end
               end
            end
         end
      end else if (cfg_enable[idx]) begin
         rpt.key_event = unread_evt[idx];
         unread_evt[idx] = kdlp_pkg::EV_NONE;
      end
      if (cfg_enable[idx])
         rpt.key_state = hold_phase[idx];
      for (int k = 0; k < kdlp_pkg::MAX_LANES; k++)
         rpt.pending_mask[k] = cfg_enable[k] && (unread_evt[k] != kdlp_pkg::EV_NONE);
      return rpt;
   endfunction

   always @(posedge clock) begin : scoreboard
      kdlp_pkg::result_type want;
      kdlp_pkg::result_type got;
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            want = next_key_report(req_ch.action, req_ch.now_ms, req_ch.raw_levels,
                                   req_ch.key_index);
            if (pin_valid)
               want = pin_rpt;
            awaited_reports.push_back(want);
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            got = '{rsp_ch.key_state_out, rsp_ch.key_event_out, rsp_ch.pending_mask};
            if (awaited_reports.size() == 0) begin
               $error("unexpected word: state %0d event %0d mask %02h",
                      got.key_state, got.key_event, got.pending_mask);
               mismatch_count++;
            end else begin
               want = awaited_reports.pop_front();
               if (got.key_state !== want.key_state) begin
                  $error("key_state_out: expected %0d, got %0d", want.key_state, got.key_state);
                  mismatch_count++;
               end
               if (got.key_event !== want.key_event) begin
                  $error("key_event_out: expected %0d, got %0d", want.key_event, got.key_event);
                  mismatch_count++;
               end
               if (got.pending_mask !== want.pending_mask) begin
                  $error("pending_mask: expected %02h, got %02h",
                         want.pending_mask, got.pending_mask);
                  mismatch_count++;
               end
            end
         end
      end
   end

   // sink side: own stall pattern, plus a long hold-off on request
   initial begin : rsp_side
      int cyc;
      int hold_left;
      cyc = 0;
      hold_left = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         cyc++;
         if (long_hold_req && hold_left == 0) begin
            hold_left = 80;
            long_hold_req = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            case ((cyc / 97) % 4)
               0: rsp_ch.ready <= 1'b1;
               1: rsp_ch.ready <= ($urandom_range(0, 1) == 1);
               2: rsp_ch.ready <= (cyc % 3 == 0);
               default: rsp_ch.ready <= ($urandom_range(0, 4) != 0);
            endcase
         end
      end
   end

   task automatic write_reg(input logic [1:0] sel, input logic [15:0] val);
      csr_we <= 1'b1;
      csr_index <= sel;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      case (sel)
         kdlp_pkg::CSR_KEY_ENABLE:  cfg_enable = val[7:0];
         kdlp_pkg::CSR_ACTIVE_HIGH: cfg_polarity = val[7:0];
         kdlp_pkg::CSR_DEBOUNCE:    cfg_debounce = val;
         kdlp_pkg::CSR_LONG_PRESS:  cfg_long = val;
         default: ;
      endcase
      @(negedge clock);
   endtask

   // called and returns at a falling edge
   task automatic send_word(input logic act, input logic [31:0] now, input logic [7:0] raw,
                            input logic [2:0] idx, input logic fix,
                            input kdlp_pkg::result_type rpt);
      int gap;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 120)
                                                  : $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_ch.valid <= 1'b1;
      req_ch.action <= act;
      req_ch.now_ms <= now;
      req_ch.raw_levels <= raw;
      req_ch.key_index <= idx;
      pin_valid <= fix;
      pin_rpt <= rpt;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic wait_drain();
      req_ch.valid <= 1'b0;
      pin_valid <= 1'b0;
      while (awaited_reports.size() != 0) @(negedge clock);
      repeat (2) @(negedge clock);
   endtask

   initial begin : stimulus
      int          db;
      int          lp;
      logic [2:0]  bit_no;
      logic [31:0] now_clk;
      logic [31:0] step;
      logic [7:0]  raw_now;
      logic [15:0] en_val;
      logic [15:0] pol_val;
      logic [15:0] db_val;
      logic [15:0] lp_val;

      req_ch.valid = 1'b0;
      req_ch.action = kdlp_pkg::ACT_SCAN;
      req_ch.now_ms = '0;
      req_ch.raw_levels = '0;
      req_ch.key_index = '0;
      csr_we = 1'b0;
      csr_index = kdlp_pkg::CSR_KEY_ENABLE;
      csr_wdata = '0;
      pin_valid = 1'b0;
      pin_rpt = IDLE_REPORT;
      cfg_enable = 8'h00;
      cfg_polarity = 8'h00;
      cfg_debounce = kdlp_pkg::DEBOUNCE_RESET;
      cfg_long = kdlp_pkg::LONG_PRESS_RESET;
      for (int k = 0; k < kdlp_pkg::MAX_LANES; k++) begin
         seen_level[k] = 1'b0;
         settle_stamp[k] = '0;
         hold_phase[k] = kdlp_pkg::PHASE_IDLE;
         unread_evt[k] = kdlp_pkg::EV_NONE;
      end

      repeat (3) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_CSR) begin
            wait_drain();
            write_reg(directed_rows[i].reg_sel, directed_rows[i].reg_val);
         end else begin
            send_word(directed_rows[i].action, directed_rows[i].now_ms,
                      directed_rows[i].raw_levels, directed_rows[i].key_index,
                      directed_rows[i].fixed, directed_rows[i].fixed_rpt);
         end
      end

      for (int phase_no = 0; phase_no < 17; phase_no++) begin
         wait_drain();
         case (phase_no)
            0: en_val = 16'h00FF;
            1: en_val = 16'h0001;
            5: en_val = 16'h0000;
            default: en_val = 16'($urandom_range(0, 255) | $urandom_range(0, 255));
         endcase
         case (phase_no % 4)
            0: pol_val = 16'h0000;
            1: pol_val = 16'h00FF;
            default: pol_val = 16'($urandom_range(0, 255));
         endcase
         case (phase_no)
            2: begin db_val = 16'd0; lp_val = 16'd0; end
            7: begin db_val = 16'hFFFF; lp_val = 16'hFFFF; end
            8: begin db_val = 16'd1; lp_val = 16'hFFFF; end
            default: begin
               db_val = 16'($urandom_range(0, 40));
               lp_val = 16'($urandom_range(0, 300));
            end
         endcase
         write_reg(kdlp_pkg::CSR_KEY_ENABLE, en_val);
         write_reg(kdlp_pkg::CSR_ACTIVE_HIGH, pol_val);
         write_reg(kdlp_pkg::CSR_DEBOUNCE, db_val);
         write_reg(kdlp_pkg::CSR_LONG_PRESS, lp_val);
         db = int'(db_val);
         lp = int'(lp_val);
         now_clk = $urandom;
         raw_now = 8'($urandom_range(0, 255));

         for (int n = 0; n < 50; n++) begin
            // sink holds off while words keep coming, so the block backs up
            if ((phase_no == 3 || phase_no == 11) && n == 10)
               long_hold_req = 1'b1;
            if ($urandom_range(0, 39) == 0)
               wait_drain();
            if ($urandom_range(0, 99) < 35) begin
               send_word(kdlp_pkg::ACT_READ, $urandom, 8'($urandom_range(0, 255)),
                         3'($urandom_range(0, 7)), 1'b0, IDLE_REPORT);
            end else begin
               case ($urandom_range(0, 9))
                  0: step = 0;
                  1, 2, 3, 4: step = $urandom_range(0, db + 2);
                  5, 6, 7: step = $urandom_range(0, db + lp + 4);
                  8: step = $urandom_range(0, 2 * (db + lp) + 10);
                  default: step = $urandom;
               endcase
               now_clk = now_clk + step;
               // bounce a pin now and then, rarely scramble them all
               if ($urandom_range(0, 3) == 0) begin
                  bit_no = 3'($urandom_range(0, 7));
                  raw_now[bit_no] = ~raw_now[bit_no];
               end
               if ($urandom_range(0, 19) == 0)
                  raw_now = 8'($urandom_range(0, 255));
               send_word(kdlp_pkg::ACT_SCAN, now_clk, raw_now, 3'($urandom_range(0, 7)),
                         1'b0, IDLE_REPORT);
            end
         end
      end

      wait_drain();
      repeat (4) @(negedge clock);
      if (mismatch_count == 0 && awaited_reports.size() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   initial begin : watchdog
      #3_000_000;
      $display("Test completed with failures");
      $finish;
   end

endmodule

### files.f
rtl/kdlp_pkg.sv
rtl/kdlp_if.sv
rtl/kdlp_lane.sv
rtl/kdlp_merge.sv
rtl/key_debounce_long_press_unit.sv
dv/tb_key_debounce_long_press_unit.sv
